[hdl/upd_pkg.sv]
// ----------------------------------------------------------------------------
// upd_pkg
// Types and character constants shared by the URL percent decoder modules.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   localparam int unsigned MAX_BYTES = 3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // One classified input: up to three decoded bytes, last flag on the final one
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [1:0]                count;
      logic                      last;
   } cmd_type;

endpackage

[hdl/upd_front.sv]
// ----------------------------------------------------------------------------
// upd_front
// Accepts raw bytes, tracks the pending escape and produces a command
// holding the zero to three decoded bytes for each transfer.
// ----------------------------------------------------------------------------
module upd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  upd_pkg::req_type req,
   output logic             cmd_write,
   output upd_pkg::cmd_type cmd
);
   import upd_pkg::*;

   typedef enum logic [2:0] {
      HELD_NONE  = 3'b001,
      HELD_PCT   = 3'b010,
      HELD_DIGIT = 3'b100
   } held_type;

   held_type   held_ff, held_in;
   logic [7:0] digit_ff, digit_in;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39)      v = c - 8'h30;
      else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
      else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
      return v[3:0];
   endfunction

   always_comb begin
      logic [7:0] b;
      logic       last;
      logic       fresh;
      logic [1:0] n;
      b        = req.in_byte;
      last     = req.in_last;
      fresh    = 1'b0;
      n        = 2'd0;
      held_in  = HELD_NONE;
      digit_in = digit_ff;
      cmd      = '0;
      unique case (held_ff)
         HELD_PCT: begin
            if (is_hex(b)) begin
               if (last) begin
                  cmd.bytes[0] = CH_PERCENT;
                  cmd.bytes[1] = b;
                  n = 2'd2;
               end else begin
                  held_in  = HELD_DIGIT;
                  digit_in = b;
               end
            end else begin
               cmd.bytes[0] = CH_PERCENT;
               n     = 2'd1;
               fresh = 1'b1;
            end
         end
         HELD_DIGIT: begin
            if (is_hex(b)) begin
               cmd.bytes[0] = {hex_val(digit_ff), hex_val(b)};
               n = 2'd1;
            end else begin
               cmd.bytes[0] = CH_PERCENT;
               cmd.bytes[1] = digit_ff;
               n     = 2'd2;
               fresh = 1'b1;
            end
         end
         default: fresh = 1'b1;
      endcase
      if (fresh) begin
         if (b == CH_PLUS) begin
            cmd.bytes[n] = CH_SPACE;
            n = n + 2'd1;
         end else if (b == CH_PERCENT && !last) begin
            held_in = HELD_PCT;
         end else begin
            cmd.bytes[n] = b;
            n = n + 2'd1;
         end
      end
      if (last) held_in = HELD_NONE;
      cmd.count = n;
      cmd.last  = last;
      cmd_write = accept && (n != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= HELD_NONE;
         digit_ff <= 8'h00;
      end else if (accept) begin
         held_ff  <= held_in;
         digit_ff <= digit_in;
      end
   end

endmodule

[hdl/upd_queue.sv]
// ----------------------------------------------------------------------------
// upd_queue
// Short command queue between the classifier and the byte serializer.
// ----------------------------------------------------------------------------
module upd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             write,
   input  upd_pkg::cmd_type wr_cmd,
   output logic             full,
   output logic             head_valid,
   output upd_pkg::cmd_type head,
   input  logic             release_head
);
   import upd_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   cmd_type       slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = write ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = release_head ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (write && !release_head)      count_in = count_ff + CW'(1);
      else if (!write && release_head) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write) slots_ff[wr_ptr_ff] <= wr_cmd;
   end

endmodule

[hdl/upd_back.sv]
// ----------------------------------------------------------------------------
// upd_back
// Walks head bytes one per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
module upd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  upd_pkg::cmd_type head,
   output logic             release_head,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output upd_pkg::rsp_type rsp_data
);
   import upd_pkg::*;

   logic       valid_ff, valid_in;
   rsp_type    data_ff;
   logic [1:0] sub_ff, sub_in;
   logic       load, take, end_of_cmd;

   assign load         = !valid_ff || rsp_pop;
   assign take         = load && head_valid;
   assign end_of_cmd   = (sub_ff == head.count - 2'd1);
   assign release_head = take && end_of_cmd;
   assign rsp_empty    = !valid_ff;
   assign rsp_data     = data_ff;

   always_comb begin
      valid_in = valid_ff;
      sub_in   = sub_ff;
      if (take) begin
         valid_in = 1'b1;
         sub_in   = end_of_cmd ? 2'd0 : sub_ff + 2'd1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff.out_byte <= head.bytes[sub_ff];
         data_ff.out_last <= head.last && end_of_cmd;
      end
   end

endmodule

[hdl/url_percent_decoder.sv]
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent decoder with queue-style ports on both sides.
// ----------------------------------------------------------------------------
// One encoded byte is taken per cycle while full is low; '+' becomes a space
// and '%' with two hex digits becomes the encoded byte. A broken or
// truncated escape passes through raw. The classifier decides every byte in
// the cycle it arrives and writes zero to three decoded bytes into a
// QUEUE_DEPTH-entry command queue; the serializer drains that queue into an
// output register at one decoded byte per cycle while the receiver pops.
// Since decoded bytes never outnumber raw bytes, a steady input of one byte
// per cycle is then sustained; decoded bytes pass through the queue and then
// the output register. full is raised only when the command queue is full.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  upd_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output upd_pkg::rsp_type rsp_data
);
   import upd_pkg::*;

   logic    accept;
   logic    cmd_write;
   cmd_type cmd;
   logic    head_valid;
   cmd_type head;
   logic    release_head;

   assign accept = req_push && !req_full;

   upd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .cmd_write (cmd_write),
      .cmd       (cmd)
   );

   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .write        (cmd_write),
      .wr_cmd       (cmd),
      .full         (req_full),
      .head_valid   (head_valid),
      .head         (head),
      .release_head (release_head)
   );

   upd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .release_head (release_head),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

endmodule

[bench/url_percent_decoder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_decoder_test
// Self-checking bench for the streaming URL percent decoder.
// ----------------------------------------------------------------------------
// Encoded strings are pushed one byte per transfer; a tracker class mirrors
// the decoder state and queues the decoded bytes each raw byte produces.
// Every popped byte is compared against the oldest queued one. A short
// directed set covers plus, good escapes in both cases and every way an
// escape can break or be cut off; random strings with mostly well-formed
// escapes follow, with sender gaps and receiver stalls varied per phase.
// ----------------------------------------------------------------------------
module url_percent_decoder_test;

   import upd_pkg::*;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_PERCENT,
      HOLD_DIGIT
   } hold_type;

   class decoded_byte_tracker;
      hold_type   held;
      logic [7:0] held_digit;
      rsp_type    awaited[$];
      int         errors;

      function new();
         held       = HOLD_NONE;
         held_digit = '0;
         errors     = 0;
      endfunction

      static function bit is_hex(logic [7:0] c);
         return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
                (c >= "a" && c <= "f");
      endfunction

      static function logic [3:0] nibble(logic [7:0] c);
         logic [7:0] v;
         if (c >= "0" && c <= "9") v = c - "0";
         else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
         else v = c - "a" + 8'd10;
         return v[3:0];
      endfunction

      function void push_out(logic [7:0] b, logic last);
         awaited.push_back(rsp_type'{out_byte: b, out_last: last});
      endfunction

      function void decode_fresh(logic [7:0] b, logic last);
         if (b == CH_PLUS) begin
            push_out(CH_SPACE, last);
         end else if (b == CH_PERCENT) begin
            if (last) push_out(CH_PERCENT, 1'b1);
            else held = HOLD_PERCENT;
         end else begin
            push_out(b, last);
         end
      endfunction

      // Called on every accepted raw byte
      function void take_raw_byte(req_type r);
         hold_type   was;
         logic [7:0] b;
         logic       last;
         was  = held;
         b    = r.in_byte;
         last = r.in_last;
         held = HOLD_NONE;
         case (was)
            HOLD_PERCENT: begin
               if (is_hex(b)) begin
                  if (last) begin
                     push_out(CH_PERCENT, 1'b0);
                     push_out(b, 1'b1);
                  end else begin
                     held_digit = b;
                     held       = HOLD_DIGIT;
                  end
               end else begin
                  push_out(CH_PERCENT, 1'b0);
                  decode_fresh(b, last);
               end
            end
            HOLD_DIGIT: begin
               if (is_hex(b)) begin
                  push_out({nibble(held_digit), nibble(b)}, last);
               end else begin
                  // broken escape: held '%' and digit go out raw
                  push_out(CH_PERCENT, 1'b0);
                  push_out(held_digit, 1'b0);
                  decode_fresh(b, last);
               end
            end
            default: decode_fresh(b, last);
         endcase
         if (last) held = HOLD_NONE;
      endfunction

      function void match_decoded_byte(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $error("unexpected decoded byte out_byte=%h out_last=%b",
                   got.out_byte, got.out_last);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
            errors++;
         end
         if (got.out_last !== want.out_last) begin
            $error("out_last: expected %b, actual %b", want.out_last, got.out_last);
            errors++;
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic    clock;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop  = 1'b0;
   rsp_type rsp_data;

   decoded_byte_tracker tracker;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int recv_hold_off = 0;
   int bytes_sent = 0;

   url_percent_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Transfer monitor: values seen here are the ones before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) tracker.take_raw_byte(req_data);
         if (rsp_pop && !rsp_empty) tracker.match_decoded_byte(rsp_data);
      end
   end

   // Receiver: random stalls, plus a counted hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (recv_hold_off > 0) begin
            rsp_pop <= 1'b0;
            recv_hold_off--;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      req_data <= req_type'{in_byte: b, in_last: last};
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      bytes_sent++;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(string s, logic end_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], end_last && (i == s.len() - 1));
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (tracker.outstanding() != 0);
   endtask

   function automatic logic [7:0] pick_hex();
      int unsigned v;
      v = $urandom_range(15);
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
   endfunction

   function automatic logic [7:0] pick_non_hex();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      while (decoded_byte_tracker::is_hex(c)) c = 8'($urandom_range(255));
      return c;
   endfunction

   // One string: mostly plain bytes, pluses and good escapes, some broken
   task automatic send_random_string();
      logic [7:0] text[$];
      int parts;
      int kind;
      bit cut;
      parts = $urandom_range(1, 6);
      cut = 1'b0;
      for (int k = 0; k < parts && !cut; k++) begin
         kind = $urandom_range(99);
         if (kind < 50) begin
            text.push_back(8'($urandom_range(255)));
         end else if (kind < 60) begin
            text.push_back(CH_PLUS);
         end else if (kind < 88) begin
            text.push_back(CH_PERCENT);
            text.push_back(pick_hex());
            text.push_back(pick_hex());
         end else if (kind < 92) begin
            text.push_back(CH_PERCENT);
            text.push_back(pick_non_hex());
         end else if (kind < 96) begin
            text.push_back(CH_PERCENT);
            text.push_back(pick_hex());
            text.push_back(pick_non_hex());
         end else begin
            // escape cut off by the end of the string
            text.push_back(CH_PERCENT);
            if ($urandom_range(1)) text.push_back(pick_hex());
            cut = 1'b1;
         end
      end
      for (int i = 0; i < text.size(); i++)
         send_byte(text[i], i == text.size() - 1);
   endtask

   initial begin
      int idle_tab[4];
      int stall_tab[4];
      int target;
      idle_tab  = '{0, 46, 0, 17};
      stall_tab = '{0, 0, 46, 17};
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte extremes, plus, escapes, broken and cut escapes
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_text("+", 1'b1);
      send_text("%41", 1'b1);
      send_text("%fF", 1'b1);
      send_text("%g", 1'b0);
      send_text("%4z", 1'b0);
      send_text("%4%20", 1'b1);
      send_text("%", 1'b1);
      send_text("%9", 1'b1);
      send_text("%a+", 1'b1);
      wait_drained();

      target = bytes_sent;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_tab[p];
         recv_stall_pct = stall_tab[p];
         // first phase: receiver holds off while bytes keep coming
         if (p == 0) recv_hold_off = 60;
         target += 72;
         while (bytes_sent < target) send_random_string();
         wait_drained();
      end

      recv_stall_pct = 0;
      repeat (10) @(posedge clock);
      if (tracker.outstanding() != 0) begin
         $error("%0d decoded bytes never arrived", tracker.outstanding());
         tracker.errors++;
      end
      if (tracker.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[files.f]
hdl/upd_pkg.sv
hdl/upd_front.sv
hdl/upd_queue.sv
hdl/upd_back.sv
hdl/url_percent_decoder.sv
bench/url_percent_decoder_test.sv
